/* design/fpgs_pkg.sv */
// ----------------------------------------------------------------------------
// fpgs_pkg
// Shared types, codes and constants for the fuzzy PID gain scheduler.
// ----------------------------------------------------------------------------
package fpgs_pkg;

   // Field widths
   localparam int DATA_W        = 16;
   localparam int MODE_W        = 3;
   localparam int INDEX_W       = 6;
   localparam int RULE_SIDE_DEF = 7;

   // Membership weights are Q1.15
   localparam int FRAC_W   = 15;
   localparam int WEIGHT_W = FRAC_W + 1;
   localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = WEIGHT_W'(1) << FRAC_W;

   // Sequencer counter: covers breakpoint indexes and divider steps
   localparam int CNT_W  = 4;
   localparam int TERM_W = 2;

   // Item modes
   localparam logic [MODE_W-1:0] MODE_COMPUTE  = 3'd0;
   localparam logic [MODE_W-1:0] MODE_LOAD_EBP = 3'd1;
   localparam logic [MODE_W-1:0] MODE_LOAD_CBP = 3'd2;
   localparam logic [MODE_W-1:0] MODE_LOAD_KP  = 3'd3;
   localparam logic [MODE_W-1:0] MODE_LOAD_KD  = 3'd4;

   // Blend terms, in issue order
   localparam logic [TERM_W-1:0] TERM_EF = 2'd0;
   localparam logic [TERM_W-1:0] TERM_EB = 2'd1;
   localparam logic [TERM_W-1:0] TERM_CF = 2'd2;
   localparam logic [TERM_W-1:0] TERM_CB = 2'd3;

   // Output saturation bounds
   localparam logic signed [DATA_W-1:0] GAIN_MAX = 16'sh7FFF;
   localparam logic signed [DATA_W-1:0] GAIN_MIN = 16'sh8000;

   typedef struct packed {
      logic        [MODE_W-1:0]  mode;
      logic signed [DATA_W-1:0]  error_value;
      logic signed [DATA_W-1:0]  error_rate;
      logic        [INDEX_W-1:0] entry_index;
      logic signed [DATA_W-1:0]  entry_value;
   } req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] kp_gain;
      logic signed [DATA_W-1:0] kd_gain;
   } rsp_type;

   // Controller to datapath
   typedef struct packed {
      logic              accept;
      logic              side;
      logic              rd_en;
      logic [CNT_W-1:0]  rd_idx;
      logic              div_load;
      logic              div_step;
      logic              weight_save;
      logic              acc_clear;
      logic              mac_issue;
      logic [TERM_W-1:0] term;
      logic              result_load;
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic out_free;
   } sts_type;

endpackage

/* design/fpgs_datapath.sv */
// ----------------------------------------------------------------------------
// fpgs_datapath
// Breakpoint and rule stores, segment search, shared weight divider,
// multiply-accumulate for both gains and the result register.
// ----------------------------------------------------------------------------
module fpgs_datapath #(
   parameter int RULE_SIDE = fpgs_pkg::RULE_SIDE_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  fpgs_pkg::req_type req_data,
   input  fpgs_pkg::cmd_type cmd,
   input  logic              rsp_ready,
   output fpgs_pkg::sts_type sts,
   output logic              rsp_valid,
   output fpgs_pkg::rsp_type rsp_data
);

   localparam int DW    = fpgs_pkg::DATA_W;
   localparam int DFW   = DW + 1;
   localparam int WW    = fpgs_pkg::WEIGHT_W;
   localparam int FW    = fpgs_pkg::FRAC_W;
   localparam int LAST  = RULE_SIDE - 1;
   localparam int RULES = RULE_SIDE * RULE_SIDE;
   localparam int BIW   = $clog2(RULE_SIDE);
   localparam int RIW   = $clog2(RULES);
   localparam int IXW   = ((RIW > fpgs_pkg::INDEX_W) ? RIW : fpgs_pkg::INDEX_W) + 1;
   localparam int PW    = WW + 1 + DW;
   localparam int AW    = PW + 2;
   localparam int SHW   = AW - 16;

   // Stores
   logic signed [DW-1:0] ebp_mem [RULE_SIDE];
   logic signed [DW-1:0] cbp_mem [RULE_SIDE];
   logic signed [DW-1:0] kp_mem  [RULES];
   logic signed [DW-1:0] kd_mem  [RULES];

   logic signed [DW-1:0] ebp_rd_ff, cbp_rd_ff, kp_rd_ff, kd_rd_ff;

   logic [IXW-1:0] idx_wide;
   logic           bp_ok, rule_ok;

   // Item operands
   logic signed [DW-1:0] xe_ff, xc_ff;

   // Segment search
   logic                 proc_valid_ff;
   logic [fpgs_pkg::CNT_W-1:0] proc_idx_ff;
   logic [fpgs_pkg::CNT_W-1:0] idx_less;
   logic signed [DW-1:0] x_sel, bp_sel;
   logic signed [DW-1:0] prev_ff, bp0_ff, bplast_ff, hi_ff, lo_ff;
   logic                 found_ff;
   logic [BIW-1:0]       k_ff;

   // Divider
   logic signed [DFW-1:0] num, den;
   logic [DFW-1:0]        rem_ff, den_ff;
   logic [DFW:0]          shifted, trial;
   logic [FW-1:0]         q_ff;
   logic                  in_range_ff, sat_ff;
   logic [WW-1:0]         front;

   // Weights and segments
   logic [WW-1:0]  ef_ff, eb_ff, cf_ff, cb_ff;
   logic [BIW-1:0] r_ff, c_ff;

   // Blend
   logic                 row_off, col_off;
   logic [RIW-1:0]       rule_addr;
   logic                 mac_valid_ff, prod_valid_ff;
   logic [fpgs_pkg::TERM_W-1:0] term_d_ff;
   logic [WW-1:0]        w_sel;
   logic signed [PW-1:0] prod_kp_ff, prod_kd_ff;
   logic signed [AW-1:0] acc_kp_ff, acc_kd_ff;

   // Result
   logic              rsp_valid_ff;
   fpgs_pkg::rsp_type rsp_data_ff;

   function automatic logic signed [DW-1:0] sat_gain(input logic signed [AW-1:0] acc);
      logic signed [SHW-1:0] sh;
      sh = SHW'(acc >>> 16);
      if (sh > SHW'(fpgs_pkg::GAIN_MAX)) begin
         return fpgs_pkg::GAIN_MAX;
      end else if (sh < SHW'(fpgs_pkg::GAIN_MIN)) begin
         return fpgs_pkg::GAIN_MIN;
      end
      return sh[DW-1:0];
   endfunction

   // Load writes land on the transfer itself
   assign idx_wide = IXW'(req_data.entry_index);
   assign bp_ok    = idx_wide < IXW'(RULE_SIDE);
   assign rule_ok  = idx_wide < IXW'(RULES);

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         case (req_data.mode)
            fpgs_pkg::MODE_LOAD_EBP: begin
               if (bp_ok) ebp_mem[idx_wide[BIW-1:0]] <= req_data.entry_value;
            end
            fpgs_pkg::MODE_LOAD_CBP: begin
               if (bp_ok) cbp_mem[idx_wide[BIW-1:0]] <= req_data.entry_value;
            end
            fpgs_pkg::MODE_LOAD_KP: begin
               if (rule_ok) kp_mem[idx_wide[RIW-1:0]] <= req_data.entry_value;
            end
            fpgs_pkg::MODE_LOAD_KD: begin
               if (rule_ok) kd_mem[idx_wide[RIW-1:0]] <= req_data.entry_value;
            end
            default: begin
            end
         endcase
         xe_ff <= req_data.error_value;
         xc_ff <= req_data.error_rate;
      end
   end

   // Breakpoint reads, registered
   always_ff @(posedge clock) begin
      if (cmd.rd_en) begin
         ebp_rd_ff <= ebp_mem[cmd.rd_idx[BIW-1:0]];
         cbp_rd_ff <= cbp_mem[cmd.rd_idx[BIW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         proc_valid_ff <= 1'b0;
      end else begin
         proc_valid_ff <= cmd.rd_en;
      end
      proc_idx_ff <= cmd.rd_idx;
   end

   assign x_sel    = cmd.side ? xc_ff : xe_ff;
   assign bp_sel   = cmd.side ? cbp_rd_ff : ebp_rd_ff;
   assign idx_less = proc_idx_ff - fpgs_pkg::CNT_W'(1);

   // Segment search: first inner breakpoint above x, else the last segment
   always_ff @(posedge clock) begin
      if (proc_valid_ff) begin
         prev_ff <= bp_sel;
         if (proc_idx_ff == '0) begin
            bp0_ff   <= bp_sel;
            found_ff <= 1'b0;
         end else if (proc_idx_ff == fpgs_pkg::CNT_W'(LAST)) begin
            bplast_ff <= bp_sel;
            if (!found_ff) begin
               found_ff <= 1'b1;
               k_ff     <= BIW'(LAST - 1);
               hi_ff    <= bp_sel;
               lo_ff    <= prev_ff;
            end
         end else if (!found_ff && (x_sel < bp_sel)) begin
            found_ff <= 1'b1;
            k_ff     <= idx_less[BIW-1:0];
            hi_ff    <= bp_sel;
            lo_ff    <= prev_ff;
         end
      end
   end

   // Restoring divider for the front weight
   assign num     = $signed({hi_ff[DW-1], hi_ff}) - $signed({x_sel[DW-1], x_sel});
   assign den     = $signed({hi_ff[DW-1], hi_ff}) - $signed({lo_ff[DW-1], lo_ff});
   assign shifted = {rem_ff, 1'b0};
   assign trial   = shifted - {1'b0, den_ff};

   always_ff @(posedge clock) begin
      if (cmd.div_load) begin
         in_range_ff <= (x_sel > bp0_ff) && (x_sel < bplast_ff);
         sat_ff      <= (den <= 0) || (num >= den);
         rem_ff      <= num;
         den_ff      <= den;
         q_ff        <= '0;
      end else if (cmd.div_step) begin
         if (shifted >= {1'b0, den_ff}) begin
            rem_ff <= trial[DFW-1:0];
            q_ff   <= {q_ff[FW-2:0], 1'b1};
         end else begin
            rem_ff <= shifted[DFW-1:0];
            q_ff   <= {q_ff[FW-2:0], 1'b0};
         end
      end
   end

   assign front = !in_range_ff ? '0 : (sat_ff ? fpgs_pkg::WEIGHT_ONE : {1'b0, q_ff});

   // Weights per side; E behind is zero out of range, EC behind is not
   always_ff @(posedge clock) begin
      if (cmd.weight_save) begin
         if (!cmd.side) begin
            ef_ff <= front;
            eb_ff <= in_range_ff ? (fpgs_pkg::WEIGHT_ONE - front) : '0;
            r_ff  <= in_range_ff ? k_ff : '0;
         end else begin
            cf_ff <= front;
            cb_ff <= fpgs_pkg::WEIGHT_ONE - front;
            c_ff  <= in_range_ff ? k_ff : '0;
         end
      end
   end

   // Rule address for the current term
   assign row_off   = (cmd.term == fpgs_pkg::TERM_EB) || (cmd.term == fpgs_pkg::TERM_CB);
   assign col_off   = (cmd.term == fpgs_pkg::TERM_CF) || (cmd.term == fpgs_pkg::TERM_CB);
   assign rule_addr = RIW'((int'(r_ff) + int'(row_off)) * RULE_SIDE
                           + int'(c_ff) + int'(col_off));

   always_ff @(posedge clock) begin
      if (cmd.mac_issue) begin
         kp_rd_ff <= kp_mem[rule_addr];
         kd_rd_ff <= kd_mem[rule_addr];
      end
   end

   always_comb begin
      case (term_d_ff)
         fpgs_pkg::TERM_EF: w_sel = ef_ff;
         fpgs_pkg::TERM_EB: w_sel = eb_ff;
         fpgs_pkg::TERM_CF: w_sel = cf_ff;
         fpgs_pkg::TERM_CB: w_sel = cb_ff;
         default:           w_sel = '0;
      endcase
   end

   // Multiply into a product register, then accumulate
   always_ff @(posedge clock) begin
      if (reset) begin
         mac_valid_ff  <= 1'b0;
         prod_valid_ff <= 1'b0;
      end else begin
         mac_valid_ff  <= cmd.mac_issue;
         prod_valid_ff <= mac_valid_ff;
      end
      term_d_ff  <= cmd.term;
      prod_kp_ff <= $signed({1'b0, w_sel}) * kp_rd_ff;
      prod_kd_ff <= $signed({1'b0, w_sel}) * kd_rd_ff;
      if (cmd.acc_clear) begin
         acc_kp_ff <= '0;
         acc_kd_ff <= '0;
      end else if (prod_valid_ff) begin
         acc_kp_ff <= acc_kp_ff + AW'(prod_kp_ff);
         acc_kd_ff <= acc_kd_ff + AW'(prod_kd_ff);
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.result_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (cmd.result_load) begin
         rsp_data_ff.kp_gain <= sat_gain(acc_kp_ff);
         rsp_data_ff.kd_gain <= sat_gain(acc_kd_ff);
      end
   end

   assign sts.out_free = !rsp_valid_ff || rsp_ready;
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_data     = rsp_data_ff;

endmodule

/* design/fpgs_ctrl.sv */
// ----------------------------------------------------------------------------
// fpgs_ctrl
// Sequencer: search, divide and weigh each axis, then blend and publish.
// ----------------------------------------------------------------------------
module fpgs_ctrl #(
   parameter int RULE_SIDE = fpgs_pkg::RULE_SIDE_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   input  logic [fpgs_pkg::MODE_W-1:0]       req_mode,
   input  fpgs_pkg::sts_type                 sts,
   output logic                              req_ready,
   output fpgs_pkg::cmd_type                 cmd
);

   localparam int CW = fpgs_pkg::CNT_W;

   localparam logic [3:0] ST_IDLE     = 4'd0;
   localparam logic [3:0] ST_SCAN     = 4'd1;
   localparam logic [3:0] ST_SCAN_END = 4'd2;
   localparam logic [3:0] ST_DIV_LOAD = 4'd3;
   localparam logic [3:0] ST_DIV_RUN  = 4'd4;
   localparam logic [3:0] ST_SAVE     = 4'd5;
   localparam logic [3:0] ST_MAC      = 4'd6;
   localparam logic [3:0] ST_MAC_END  = 4'd7;
   localparam logic [3:0] ST_FINISH   = 4'd8;

   logic [3:0]    state_ff, state_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          side_ff, side_in;
   logic          accept;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;

   // Next state and commands
   always_comb begin
      state_in        = state_ff;
      cnt_in          = cnt_ff;
      side_in         = side_ff;
      cmd             = '0;
      cmd.accept      = accept;
      cmd.side        = side_ff;
      cmd.rd_idx      = cnt_ff;
      cmd.term        = cnt_ff[fpgs_pkg::TERM_W-1:0];
      case (state_ff)
         ST_IDLE: begin
            if (accept && (req_mode == fpgs_pkg::MODE_COMPUTE)) begin
               state_in = ST_SCAN;
               cnt_in   = '0;
               side_in  = 1'b0;
            end
         end
         ST_SCAN: begin
            cmd.rd_en = 1'b1;
            if (cnt_ff == CW'(RULE_SIDE - 1)) begin
               state_in = ST_SCAN_END;
            end else begin
               cnt_in = cnt_ff + CW'(1);
            end
         end
         ST_SCAN_END: begin
            state_in = ST_DIV_LOAD;
         end
         ST_DIV_LOAD: begin
            cmd.div_load = 1'b1;
            cnt_in       = '0;
            state_in     = ST_DIV_RUN;
         end
         ST_DIV_RUN: begin
            cmd.div_step = 1'b1;
            if (cnt_ff == CW'(fpgs_pkg::FRAC_W - 1)) begin
               state_in = ST_SAVE;
            end else begin
               cnt_in = cnt_ff + CW'(1);
            end
         end
         ST_SAVE: begin
            cmd.weight_save = 1'b1;
            cnt_in          = '0;
            if (!side_ff) begin
               side_in  = 1'b1;
               state_in = ST_SCAN;
            end else begin
               cmd.acc_clear = 1'b1;
               state_in      = ST_MAC;
            end
         end
         ST_MAC: begin
            cmd.mac_issue = 1'b1;
            if (cnt_ff == CW'(3)) begin
               cnt_in   = '0;
               state_in = ST_MAC_END;
            end else begin
               cnt_in = cnt_ff + CW'(1);
            end
         end
         ST_MAC_END: begin
            // drain the read and multiply stages
            if (cnt_ff == CW'(1)) begin
               state_in = ST_FINISH;
            end else begin
               cnt_in = cnt_ff + CW'(1);
            end
         end
         ST_FINISH: begin
            if (sts.out_free) begin
               cmd.result_load = 1'b1;
               state_in        = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
         side_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         side_ff  <= side_in;
      end
   end

endmodule

/* design/fuzzy_pid_gain_scheduler.sv */
// ----------------------------------------------------------------------------
// fuzzy_pid_gain_scheduler
// Fuzzy Kp/Kd gain scheduling over a square rule grid.
// ----------------------------------------------------------------------------
// Load items (breakpoints, rule entries) are written on the transfer and the
// block is ready again next cycle; they give no result. A compute item runs
// per axis one breakpoint read a cycle from a single-port store, then a
// 15-step restoring divider for the Q1.15 weight, then four rule reads into
// one multiplier per gain. One item is in work at a time; a finished result
// waits in its output register while the next item is taken.
module fuzzy_pid_gain_scheduler #(
   parameter int RULE_SIDE = fpgs_pkg::RULE_SIDE_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  fpgs_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output fpgs_pkg::rsp_type rsp_data
);

   fpgs_pkg::cmd_type cmd;
   fpgs_pkg::sts_type sts;

   fpgs_ctrl #(.RULE_SIDE(RULE_SIDE)) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_mode  (req_data.mode),
      .sts       (sts),
      .req_ready (req_ready),
      .cmd       (cmd)
   );

   fpgs_datapath #(.RULE_SIDE(RULE_SIDE)) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .rsp_ready (rsp_ready),
      .sts       (sts),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

`ifndef SYNTH
   // a load transfer leaves the block ready
   a_load_ready: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && (req_data.mode != fpgs_pkg::MODE_COMPUTE))
      |=> req_ready)
      else $error("load transfer left block busy");

   // a compute transfer makes the block busy
   a_compute_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && (req_data.mode == fpgs_pkg::MODE_COMPUTE))
      |=> !req_ready)
      else $error("compute transfer did not start work");

   // a new result only appears at the end of busy work
   a_result_after_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(!req_ready))
      else $error("result without compute work");
`endif

endmodule
